@@ rtl/ues_pkg.sv @@
// Shared types and constants for the UTF-8 emoji strip filter.
package ues_pkg;

    localparam int unsigned MAX_BYTES = 5;
    localparam int unsigned CNT_W     = 3;

    localparam logic [0:0] CMD_DATA  = 1'b0;
    localparam logic [0:0] CMD_FLUSH = 1'b1;

    localparam logic [20:0] CP_VS16      = 21'h00FE0F;
    localparam logic [20:0] CP_KEYCAP    = 21'h0020E3;
    localparam logic [20:0] CP_ZWJ       = 21'h00200D;
    localparam logic [20:0] CP_TEN       = 21'h01F51F;
    localparam logic [20:0] CP_EMO_LO    = 21'h01F000;
    localparam logic [20:0] CP_EMO_HI    = 21'h01FAFF;
    localparam logic [20:0] CP_MISC_LO   = 21'h002600;
    localparam logic [20:0] CP_MISC_HI   = 21'h0027BF;
    localparam logic [20:0] CP_ARROW_LO  = 21'h002B00;
    localparam logic [20:0] CP_ARROW_HI  = 21'h002BFF;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;

    typedef struct packed {
        logic [0:0] command;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [0:0] last_of_run;
    } t_out_item;

    // Output bytes caused by one accepted input transaction.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          cnt;
    } t_job;

endpackage

@@ rtl/utf8_emoji_strip_filter_unit.sv @@
// Top level of the UTF-8 emoji strip filter.
//
// Takes one UTF-8 byte (or a flush command) per transaction and returns the
// filtered byte stream, one byte per result transaction, with last_of_run set
// on the final byte caused by each input. Emoji code points, U+FE0F, U+20E3
// and U+200D are removed; U+1F51F becomes "10."; a digit, '#' or '*' followed
// by a keycap mark (optionally after U+FE0F) comes out as digit + '.' or the
// plain symbol. Malformed, overlong, surrogate and out-of-range sequences are
// dropped. Rate: the front end decodes one input per cycle whenever the job
// queue has room, so an input is taken every cycle in steady state. The back
// end drains one output byte per cycle while pop keeps the result register
// free, so an input that produces N bytes (up to five) occupies the output
// side until all N are out; the job queue of QUEUE_DEPTH entries absorbs
// these bursts. full asserts only when the queue is full. When the block is
// otherwise idle, the first result of an accepted input reaches the result
// ports through the queue write, then the serializer load, then the output
// register. No configuration registers.
module utf8_emoji_strip_filter_unit
    import ues_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);

    logic accept;
    logic job_valid;
    t_job front_job;
    t_job q_job;
    logic q_full;
    logic q_nonempty;
    logic q_rd;
    logic out_valid;

    // Input transaction lands whenever the queue can take a job.
    assign full   = q_full;
    assign accept = push && !q_full;

    ues_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_job_valid (job_valid),
        .o_job       (front_job)
    );

    ues_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (job_valid),
        .i_wr_job   (front_job),
        .i_rd       (q_rd),
        .o_rd_job   (q_job),
        .o_full     (q_full),
        .o_nonempty (q_nonempty)
    );

    ues_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_q_job      (q_job),
        .o_q_rd       (q_rd),
        .i_pop        (pop),
        .o_out_valid  (out_valid),
        .o_out        (o_result)
    );

    assign empty = !out_valid;

endmodule

@@ rtl/ues_front.sv @@
// Front end: UTF-8 decode, emoji classification and keycap hold; emits byte jobs.
module ues_front
    import ues_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_job_valid,
    output t_job     o_job
);

    logic [20:0] r_cp,   n_cp;
    logic [2:0]  r_exp,  n_exp;
    logic [2:0]  r_rcv,  n_rcv;
    logic        r_hold, n_hold;
    logic        r_mark, n_mark;
    logic [6:0]  r_held, n_held;

    t_job job;

    always_comb begin
        logic [7:0]  b;
        logic        cont;
        logic        complete;
        logic        bad;
        logic [2:0]  rcv1;
        logic [20:0] cp_acc;
        logic [20:0] cp;
        logic        have_cp;
        logic        as_lead;
        logic        do_normal;
        logic [2:0]  k;

        b        = i_item.data_byte;
        n_cp     = r_cp;
        n_exp    = r_exp;
        n_rcv    = r_rcv;
        n_hold   = r_hold;
        n_mark   = r_mark;
        n_held   = r_held;
        job      = '0;
        k        = '0;
        cont     = (r_exp != 3'd0) && (b[7:6] == 2'b10);
        rcv1     = r_rcv + 3'd1;
        complete = cont && (rcv1 >= r_exp);
        cp_acc   = {r_cp[14:0], b[5:0]};
        bad      = ((r_exp == 3'd3) && (cp_acc < 21'h000800)) ||
                   ((r_exp == 3'd4) && (cp_acc < 21'h010000)) ||
                   (cp_acc > CP_MAX) ||
                   ((cp_acc >= CP_SURR_LO) && (cp_acc <= CP_SURR_HI));
        as_lead  = !cont;
        have_cp  = 1'b0;
        cp       = '0;
        do_normal = 1'b0;

        if (i_item.command == CMD_FLUSH) begin
            if (r_hold) begin
                job.bytes[k] = {1'b0, r_held};
                k = k + 3'd1;
            end
            n_hold = 1'b0;
            n_mark = 1'b0;
            n_held = '0;
            n_cp   = '0;
            n_exp  = '0;
            n_rcv  = '0;
        end else begin
            if (cont) begin
                if (complete) begin
                    n_cp  = '0;
                    n_exp = '0;
                    n_rcv = '0;
                    have_cp = !bad;
                    cp      = cp_acc;
                end else begin
                    n_cp  = cp_acc;
                    n_rcv = rcv1;
                end
            end
            if (as_lead) begin
                n_cp  = '0;
                n_exp = '0;
                n_rcv = '0;
                if (b[7] == 1'b0) begin
                    have_cp = 1'b1;
                    cp      = {14'd0, b[6:0]};
                end else if (b >= 8'hC2 && b <= 8'hDF) begin
                    n_exp = 3'd2;
                    n_rcv = 3'd1;
                    n_cp  = {16'd0, b[4:0]};
                end else if (b >= 8'hE0 && b <= 8'hEF) begin
                    n_exp = 3'd3;
                    n_rcv = 3'd1;
                    n_cp  = {17'd0, b[3:0]};
                end else if (b >= 8'hF0 && b <= 8'hF4) begin
                    n_exp = 3'd4;
                    n_rcv = 3'd1;
                    n_cp  = {18'd0, b[2:0]};
                end
            end

            if (have_cp) begin
                do_normal = 1'b1;
                if (r_hold) begin
                    if (cp == CP_KEYCAP) begin
                        // keycap: digit becomes digit + '.', '#'/'*' stay plain
                        job.bytes[k] = {1'b0, r_held};
                        k = k + 3'd1;
                        if (r_held >= 7'h30 && r_held <= 7'h39) begin
                            job.bytes[k] = 8'h2E;
                            k = k + 3'd1;
                        end
                        n_hold    = 1'b0;
                        n_mark    = 1'b0;
                        do_normal = 1'b0;
                    end else if (!r_mark && cp == CP_VS16) begin
                        n_mark    = 1'b1;
                        do_normal = 1'b0;
                    end else begin
                        job.bytes[k] = {1'b0, r_held};
                        k = k + 3'd1;
                        n_hold = 1'b0;
                        n_mark = 1'b0;
                    end
                end
                if (do_normal) begin
                    if (cp == CP_VS16 || cp == CP_KEYCAP || cp == CP_ZWJ) begin
                        k = k;
                    end else if (cp == CP_TEN) begin
                        job.bytes[k] = 8'h31;
                        k = k + 3'd1;
                        job.bytes[k] = 8'h30;
                        k = k + 3'd1;
                        job.bytes[k] = 8'h2E;
                        k = k + 3'd1;
                    end else if ((cp >= CP_EMO_LO && cp <= CP_EMO_HI) ||
                                 (cp >= CP_MISC_LO && cp <= CP_MISC_HI) ||
                                 (cp >= CP_ARROW_LO && cp <= CP_ARROW_HI)) begin
                        k = k;
                    end else if ((cp >= 21'h30 && cp <= 21'h39) ||
                                 cp == 21'h23 || cp == 21'h2A) begin
                        n_hold = 1'b1;
                        n_mark = 1'b0;
                        n_held = cp[6:0];
                    end else if (cp < 21'h80) begin
                        job.bytes[k] = {1'b0, cp[6:0]};
                        k = k + 3'd1;
                    end else if (cp < 21'h800) begin
                        job.bytes[k] = {3'b110, cp[10:6]};
                        k = k + 3'd1;
                        job.bytes[k] = {2'b10, cp[5:0]};
                        k = k + 3'd1;
                    end else if (cp < 21'h10000) begin
                        job.bytes[k] = {4'b1110, cp[15:12]};
                        k = k + 3'd1;
                        job.bytes[k] = {2'b10, cp[11:6]};
                        k = k + 3'd1;
                        job.bytes[k] = {2'b10, cp[5:0]};
                        k = k + 3'd1;
                    end else begin
                        job.bytes[k] = {5'b11110, cp[20:18]};
                        k = k + 3'd1;
                        job.bytes[k] = {2'b10, cp[17:12]};
                        k = k + 3'd1;
                        job.bytes[k] = {2'b10, cp[11:6]};
                        k = k + 3'd1;
                        job.bytes[k] = {2'b10, cp[5:0]};
                        k = k + 3'd1;
                    end
                end
            end
        end
        job.cnt = k;
    end

    assign o_job       = job;
    assign o_job_valid = i_accept && (job.cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp   <= '0;
            r_exp  <= '0;
            r_rcv  <= '0;
            r_hold <= 1'b0;
            r_mark <= 1'b0;
            r_held <= '0;
        end else if (i_accept) begin
            r_cp   <= n_cp;
            r_exp  <= n_exp;
            r_rcv  <= n_rcv;
            r_hold <= n_hold;
            r_mark <= n_mark;
            r_held <= n_held;
        end
    end

endmodule

@@ rtl/ues_queue.sv @@
// Short job queue between the decode front end and the byte serializer.
module ues_queue
    import ues_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_wr_job,
    input  logic i_rd,
    output t_job o_rd_job,
    output logic o_full,
    output logic o_nonempty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W2 = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W2-1:0] FULL_CNT = CNT_W2'(DEPTH);

    t_job              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W2-1:0] r_count;

    assign o_rd_job   = r_mem[r_rd_ptr];
    assign o_full     = (r_count == FULL_CNT);
    assign o_nonempty = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + CNT_W2'(1);
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - CNT_W2'(1);
            end
        end
    end

endmodule

@@ rtl/ues_back.sv @@
// Back end: walks each job byte by byte into the result output register.
module ues_back
    import ues_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_nonempty,
    input  t_job      i_q_job,
    output logic      o_q_rd,
    input  logic      i_pop,
    output logic      o_out_valid,
    output t_out_item o_out
);

    t_job             r_cur;
    logic             r_cur_valid;
    logic [CNT_W-1:0] r_idx;
    logic             r_out_valid;
    t_out_item        r_out;

    logic out_adv;
    logic cur_last;

    assign out_adv  = !r_out_valid || i_pop;
    assign cur_last = (r_idx == (r_cur.cnt - CNT_W'(1)));
    assign o_q_rd   = i_q_nonempty && (!r_cur_valid || (out_adv && cur_last));

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (out_adv) begin
                r_out_valid <= r_cur_valid;
            end
            if (o_q_rd) begin
                r_cur_valid <= 1'b1;
                r_idx       <= '0;
            end else if (out_adv && r_cur_valid) begin
                if (cur_last) begin
                    r_cur_valid <= 1'b0;
                end else begin
                    r_idx <= r_idx + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_cur <= i_q_job;
        end
        if (out_adv && r_cur_valid) begin
            r_out.out_byte    <= r_cur.bytes[r_idx];
            r_out.last_of_run <= cur_last;
        end
    end

endmodule

@@ test/tb.sv @@
// Self-checking testbench for utf8_emoji_strip_filter_unit: byte stream in, filtered bytes out.
`timescale 1ns / 1ps

module tb;
    import ues_pkg::*;

    localparam int unsigned RUN_LIMIT   = 200000; // watchdog, in clock cycles
    localparam int unsigned ITEM_TARGET = 310;
    localparam int unsigned DRAIN_CYCLES = 12;     // margin after the last expected byte

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_item  i_item  = '0;
    logic      full;
    logic      empty;
    t_out_item o_result;

    always #10 i_clk = ~i_clk;

    utf8_emoji_strip_filter_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    // ------------------------------------------------------------------
    // Stimulus and expectation stores
    // ------------------------------------------------------------------
    t_in_item   src_items[$];   // bytes / flushes not yet accepted
    t_out_item  want_bytes[$];  // predicted filtered bytes, oldest first
    logic [7:0] run_bytes[$];   // bytes produced by the transaction being predicted
    int unsigned n_in  = 0;     // accepted input transactions (NBA updated)
    int unsigned n_err = 0;

    // ------------------------------------------------------------------
    // Filter state as seen by the predictor
    // ------------------------------------------------------------------
    logic [20:0] cp_acc   = '0;  // code point bits gathered so far
    logic [2:0]  seq_len  = '0;  // length of pending sequence, 0 = none
    logic [2:0]  seq_cnt  = '0;  // bytes of pending sequence seen
    logic        hold_v   = 1'b0;
    logic        hold_fe0f = 1'b0;
    logic [6:0]  hold_ch  = '0;

    function automatic void put_out(input logic [7:0] b);
        run_bytes.push_back(b);
    endfunction

    function automatic void put_utf8(input logic [20:0] cp);
        if (cp < 21'h80) begin
            put_out(cp[7:0]);
        end else if (cp < 21'h800) begin
            put_out({3'b110, cp[10:6]});
            put_out({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            put_out({4'b1110, cp[15:12]});
            put_out({2'b10, cp[11:6]});
            put_out({2'b10, cp[5:0]});
        end else begin
            put_out({5'b11110, cp[20:18]});
            put_out({2'b10, cp[17:12]});
            put_out({2'b10, cp[11:6]});
            put_out({2'b10, cp[5:0]});
        end
    endfunction

    function automatic void release_held();
        put_out({1'b0, hold_ch});
        hold_v    = 1'b0;
        hold_fe0f = 1'b0;
    endfunction

    // One decoded code point through the strip / keycap logic.
    function automatic void strip_cp(input logic [20:0] cp);
        if (hold_v) begin
            if (cp == CP_KEYCAP) begin
                // keycap: digit becomes digit + '.', '#' and '*' stay plain
                put_out({1'b0, hold_ch});
                if (hold_ch >= 7'h30 && hold_ch <= 7'h39)
                    put_out(8'h2E);
                hold_v    = 1'b0;
                hold_fe0f = 1'b0;
                return;
            end
            if (!hold_fe0f && cp == CP_VS16) begin
                hold_fe0f = 1'b1;
                return;
            end
            release_held();
        end
        if (cp == CP_VS16 || cp == CP_KEYCAP || cp == CP_ZWJ)
            return;
        if (cp == CP_TEN) begin
            put_out(8'h31);
            put_out(8'h30);
            put_out(8'h2E);
            return;
        end
        if ((cp >= CP_EMO_LO && cp <= CP_EMO_HI) ||
            (cp >= CP_MISC_LO && cp <= CP_MISC_HI) ||
            (cp >= CP_ARROW_LO && cp <= CP_ARROW_HI))
            return;
        if ((cp >= 21'h30 && cp <= 21'h39) || cp == 21'h23 || cp == 21'h2A) begin
            hold_v    = 1'b1;
            hold_fe0f = 1'b0;
            hold_ch   = cp[6:0];
            return;
        end
        put_utf8(cp);
    endfunction

    // Predict the bytes caused by one accepted transaction.
    function automatic void filter_step(input t_in_item it);
        logic [7:0]  b;
        logic        as_lead;
        logic        bad;
        logic [20:0] cp;
        t_out_item   r;
        b       = it.data_byte;
        as_lead = 1'b1;
        run_bytes.delete();
        if (it.command == CMD_FLUSH) begin
            if (hold_v)
                release_held();
            hold_v    = 1'b0;
            hold_fe0f = 1'b0;
            hold_ch   = '0;
            cp_acc    = '0;
            seq_len   = '0;
            seq_cnt   = '0;
        end else begin
            if (seq_len != 0) begin
                if (b[7:6] == 2'b10) begin
                    as_lead = 1'b0;
                    cp_acc  = {cp_acc[14:0], b[5:0]};
                    seq_cnt = seq_cnt + 3'd1;
                    if (seq_cnt >= seq_len) begin
                        cp  = cp_acc;
                        bad = (seq_len == 3'd3 && cp < 21'h800) ||
                              (seq_len == 3'd4 && cp < 21'h10000) ||
                              cp > CP_MAX ||
                              (cp >= CP_SURR_LO && cp <= CP_SURR_HI);
                        seq_len = '0;
                        seq_cnt = '0;
                        cp_acc  = '0;
                        if (!bad)
                            strip_cp(cp);
                    end
                end else begin
                    // broken sequence: drop it, this byte starts over
                    seq_len = '0;
                    seq_cnt = '0;
                    cp_acc  = '0;
                end
            end
            if (as_lead) begin
                if (b < 8'h80) begin
                    strip_cp({13'd0, b});
                end else if (b >= 8'hC2 && b <= 8'hDF) begin
                    seq_len = 3'd2;
                    seq_cnt = 3'd1;
                    cp_acc  = {16'd0, b[4:0]};
                end else if (b >= 8'hE0 && b <= 8'hEF) begin
                    seq_len = 3'd3;
                    seq_cnt = 3'd1;
                    cp_acc  = {17'd0, b[3:0]};
                end else if (b >= 8'hF0 && b <= 8'hF4) begin
                    seq_len = 3'd4;
                    seq_cnt = 3'd1;
                    cp_acc  = {18'd0, b[2:0]};
                end
            end
        end
        foreach (run_bytes[i]) begin
            r.out_byte    = run_bytes[i];
            r.last_of_run = (i == run_bytes.size() - 1);
            want_bytes.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic void add_byte(input logic [7:0] b);
        t_in_item it;
        it.command   = CMD_DATA;
        it.data_byte = b;
        src_items.push_back(it);
    endfunction

    function automatic void add_flush();
        t_in_item it;
        it.command   = CMD_FLUSH;
        it.data_byte = 8'($urandom_range(0, 255)); // ignored by the block
        src_items.push_back(it);
    endfunction

    // Encode cp with a forced length, so overlong and out-of-range forms are possible.
    function automatic void add_cp(input logic [20:0] cp, input int len);
        case (len)
            2: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // Idle share in percent: sender busy-light first, then receiver, then none.
    function automatic int unsigned idle_share(input bit sender);
        if (n_in < 110)
            return sender ? 27 : 69;
        else if (n_in < 210)
            return sender ? 69 : 27;
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers the head of src_items, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                filter_step(i_item);
                void'(src_items.pop_front());
                n_in <= n_in + 1;
            end
            // a refused transaction stays on the bus until taken
            if (!(push && full)) begin
                if (src_items.size() != 0 && $urandom_range(0, 99) >= idle_share(1'b1)) begin
                    push   <= 1'b1;
                    i_item <= src_items[0];
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each popped byte, throttles pop
    // ------------------------------------------------------------------
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (want_bytes.size() == 0) begin
                    $error("unexpected result: out_byte %h last_of_run %b",
                           o_result.out_byte, o_result.last_of_run);
                    n_err++;
                end else begin
                    if (o_result.out_byte !== want_bytes[0].out_byte) begin
                        $error("out_byte: expected %h, got %h",
                               want_bytes[0].out_byte, o_result.out_byte);
                        n_err++;
                    end
                    if (o_result.last_of_run !== want_bytes[0].last_of_run) begin
                        $error("last_of_run: expected %b, got %b",
                               want_bytes[0].last_of_run, o_result.last_of_run);
                        n_err++;
                    end
                    void'(want_bytes.pop_front());
                end
            end
            // one long hold-off early on, so the job queue fills and full rises
            if (hold_left != 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (!hold_done && n_in >= 50) begin
                hold_done = 1'b1;
                hold_left = 80;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= idle_share(1'b0));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin
        repeat (RUN_LIMIT) @(posedge i_clk);
        $display("FAIL utf8_emoji_strip_filter_unit");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned r;
        int unsigned k;
        int unsigned len;
        logic [7:0]  ch;

        // directed: byte extremes, keycap with VS16, "10" keycap emoji,
        // broken sequence, surrogate, above U+10FFFF, flush of a held digit
        add_byte(8'h00);
        add_byte(8'hFF);                  // invalid lead
        add_byte(8'h39);                  // '9'
        add_cp(CP_VS16, 3);
        add_cp(CP_KEYCAP, 3);             // -> "9."
        add_cp(CP_TEN, 4);                // -> "10."
        add_byte(8'hC3);
        add_byte(8'h41);                  // bad continuation, 'A' restarts
        add_cp(21'h00D800, 3);            // surrogate
        add_byte(8'h37);                  // '7' held ...
        add_flush();                      // ... and released by flush
        add_cp(21'h110000, 4);            // above max

        // random: mostly well-formed sequences with random content
        while (src_items.size() < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                add_byte(8'($urandom_range(0, 127)));
            end else if (r < 32) begin
                // keycap candidate: held char, optional marks, keycap or not
                k  = $urandom_range(0, 11);
                ch = (k < 10) ? 8'(8'h30 + k) : ((k == 10) ? 8'h23 : 8'h2A);
                add_byte(ch);
                k = $urandom_range(0, 9);
                if (k < 5)
                    add_cp(CP_VS16, 3);
                if (k == 0)
                    add_cp(CP_VS16, 3);   // second mark releases the hold
                if ($urandom_range(0, 9) < 7)
                    add_cp(CP_KEYCAP, 3);
                else
                    add_byte(8'($urandom_range(0, 127)));
            end else if (r < 42) begin
                add_cp(21'($urandom_range(21'h80, 21'h7FF)), 2);
            end else if (r < 60) begin
                case ($urandom_range(0, 7))
                    0: add_cp(21'($urandom_range(CP_MISC_LO, CP_MISC_HI)), 3);
                    1: add_cp(21'($urandom_range(CP_ARROW_LO, CP_ARROW_HI)), 3);
                    2: begin
                        k = $urandom_range(0, 2);
                        add_cp((k == 0) ? CP_VS16 : ((k == 1) ? CP_KEYCAP : CP_ZWJ), 3);
                    end
                    3: begin
                        // just outside / on the stripped ranges
                        case ($urandom_range(0, 3))
                            0: add_cp(CP_MISC_LO - 21'd1, 3);
                            1: add_cp(CP_MISC_HI + 21'd1, 3);
                            2: add_cp(CP_ARROW_LO - 21'd1, 3);
                            default: add_cp(CP_ARROW_HI + 21'd1, 3);
                        endcase
                    end
                    4: add_cp(21'($urandom_range(CP_SURR_LO, CP_SURR_HI)), 3);
                    5: add_cp(21'($urandom_range(0, 21'h7FF)), 3);      // overlong
                    default: add_cp(21'($urandom_range(21'h800, 21'hFFFF)), 3);
                endcase
            end else if (r < 75) begin
                case ($urandom_range(0, 5))
                    0: add_cp(21'($urandom_range(CP_EMO_LO, CP_EMO_HI)), 4);
                    1: add_cp(CP_TEN, 4);
                    2: add_cp(21'($urandom_range(21'h10000, CP_MAX)), 4);
                    3: add_cp(21'($urandom_range(0, 21'hFFFF)), 4);       // overlong
                    4: add_cp(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
                    default: begin
                        case ($urandom_range(0, 3))
                            0: add_cp(CP_EMO_LO - 21'd1, 4);
                            1: add_cp(CP_EMO_HI + 21'd1, 4);
                            2: add_cp(CP_MAX, 4);
                            default: add_cp(CP_EMO_HI, 4);
                        endcase
                    end
                endcase
            end else if (r < 85) begin
                // truncated sequence: lead, some continuations, then a breaker
                len = $urandom_range(2, 4);
                case (len)
                    2: add_byte(8'($urandom_range(8'hC2, 8'hDF)));
                    3: add_byte(8'($urandom_range(8'hE0, 8'hEF)));
                    default: add_byte(8'($urandom_range(8'hF0, 8'hF4)));
                endcase
                k = $urandom_range(0, len - 2);
                repeat (k) add_byte(8'($urandom_range(8'h80, 8'hBF)));
                if ($urandom_range(0, 1) == 0)
                    add_byte(8'($urandom_range(0, 127)));
                else
                    add_byte(8'($urandom_range(8'hC0, 8'hFF)));
            end else if (r < 97) begin
                add_byte(8'($urandom_range(0, 255)));
            end else begin
                add_flush();
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (src_items.size() != 0 || want_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_err == 0)
            $display("PASS utf8_emoji_strip_filter_unit");
        else
            $display("FAIL utf8_emoji_strip_filter_unit");
        $finish;
    end

endmodule
